[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/abr_pkg.sv]
package abr_pkg;

    // Configuration port geometry.
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 5;

    // Register indexes, in address order.
    typedef enum logic [2:0] {
        REG_SRC_X    = 3'd0,
        REG_SRC_Y    = 3'd1,
        REG_SRC_Z    = 3'd2,
        REG_NEG_MASK = 3'd3,
        REG_DET_NEG  = 3'd4,
        REG_SCALE    = 3'd5
    } t_reg_idx;

    // Source code that feeds a zero axis.
    localparam logic [1:0] SRC_NONE = 2'd3;

    // Reset values: identity basis, unit scale.
    localparam logic [1:0] SRC_X_RESET = 2'd0;
    localparam logic [1:0] SRC_Y_RESET = 2'd1;
    localparam logic [1:0] SRC_Z_RESET = 2'd2;

    // Position scale is unsigned Q16.16.
    localparam int SCALE_W    = 32;
    localparam int SCALE_FRAC = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0][1:0]      src;
        logic [2:0]           neg;
        logic                 det;
        logic [SCALE_W-1:0]   scale;
        logic                 basis_ok;
    } t_cfg;

endpackage

[rtl/abr_in_if.sv]
interface abr_in_if #(
    parameter int COMPONENT_WIDTH = 32
);
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [COMPONENT_WIDTH-1:0] in_x;
    logic signed [COMPONENT_WIDTH-1:0] in_y;
    logic signed [COMPONENT_WIDTH-1:0] in_z;
    logic signed [COMPONENT_WIDTH-1:0] in_w;

    modport source (output valid, req_type, in_x, in_y, in_z, in_w, input ready);
    modport sink (input valid, req_type, in_x, in_y, in_z, in_w, output ready);
endinterface

[rtl/abr_out_if.sv]
interface abr_out_if #(
    parameter int COMPONENT_WIDTH = 32
);
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [COMPONENT_WIDTH-1:0] out_x;
    logic signed [COMPONENT_WIDTH-1:0] out_y;
    logic signed [COMPONENT_WIDTH-1:0] out_z;
    logic signed [COMPONENT_WIDTH-1:0] out_w;
    logic                              saturated;
    logic                              basis_valid;

    modport source (output valid, kind, out_x, out_y, out_z, out_w, saturated, basis_valid,
                    input ready);
    modport sink (input valid, kind, out_x, out_y, out_z, out_w, saturated, basis_valid,
                  output ready);
endinterface

[rtl/axis_basis_remap.sv]
// Path: the front stages, the square-root cells, the divide cells, then the output register.
// Throughput: one word per cycle; the length square root takes one cell per root bit
// and the normalising divide one cell per quotient bit, all pipelined.
// The whole pipeline, input included, holds while the output word waits to be taken.
// Reset is synchronous: valid flags clear and the basis returns to identity, unit scale.
`include "assert_macros.svh"

module axis_basis_remap
    import abr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 32,
    parameter int QUAT_FRAC_BITS  = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    abr_in_if.sink            i_in,
    abr_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW    = COMPONENT_WIDTH;
    localparam int LEN_W = (CW + 1 > 64) ? 64 : CW + 1;
    localparam int SQ_W  = 2 * LEN_W;
    localparam int QUO_W = QUAT_FRAC_BITS + 1;
    localparam int QR_W  = QUO_W + 1;
    localparam int X_W   = ((QR_W > CW) ? QR_W : CW) + 1;

    typedef struct packed {
        logic               kind;
        logic               bv;
        logic               zero;
        logic               sat;
        logic [3:0]         sg;
        logic [2:0][CW-1:0] res;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [3:0][CW-1:0] m;
    } t_sqrt_pay;

    localparam int SIDE_W = $bits(t_side);
    localparam int SPAY_W = $bits(t_sqrt_pay);

    logic [1:0]         r_src_x, r_src_y, r_src_z;
    logic [2:0]         r_neg;
    logic               r_det;
    logic [SCALE_W-1:0] r_scale;
    t_cfg               w_cfg;
    logic               w_cfg_wr;
    logic               w_perm_ok, w_parity;
    logic               w_en;

    logic               f_valid, f_kind, f_bv, f_sat, f_zero;
    logic [3:0]         f_sg;
    logic [2:0][CW-1:0] f_res;
    logic [3:0][CW-1:0] f_mag;
    logic [SQ_W-1:0]    f_sum;
    t_sqrt_pay          f_pay;

    logic               sq_v    [0:LEN_W];
    logic [SQ_W-1:0]    sq_s    [0:LEN_W];
    logic [LEN_W+1:0]   sq_rem  [0:LEN_W];
    logic [LEN_W-1:0]   sq_root [0:LEN_W];
    logic [SPAY_W-1:0]  sq_pay  [0:LEN_W];
    t_sqrt_pay          sq_last;

    logic                  dv_v   [0:QUO_W];
    logic [LEN_W-1:0]      dv_len [0:QUO_W];
    logic [3:0][LEN_W:0]   dv_t   [0:QUO_W];
    logic [3:0][QUO_W-1:0] dv_q   [0:QUO_W];
    logic [SIDE_W-1:0]     dv_pay [0:QUO_W];
    t_side                 dv_last;

    logic [3:0][CW-1:0] w_rot;
    logic               r_out_valid, r_out_kind, r_out_sat, r_out_bv;
    logic [3:0][CW-1:0] r_out_c;
    logic [3:0][CW-1:0] n_out_c;

    // Configuration registers, written through the APB port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= SRC_X_RESET;
            r_src_y <= SRC_Y_RESET;
            r_src_z <= SRC_Z_RESET;
            r_neg   <= '0;
            r_det   <= 1'b0;
            r_scale <= SCALE_RESET;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[CFG_AW-1:2]))
                REG_SRC_X:    r_src_x <= pwdata[1:0];
                REG_SRC_Y:    r_src_y <= pwdata[1:0];
                REG_SRC_Z:    r_src_z <= pwdata[1:0];
                REG_NEG_MASK: r_neg   <= pwdata[2:0];
                REG_DET_NEG:  r_det   <= pwdata[0];
                REG_SCALE:    r_scale <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (t_reg_idx'(paddr[CFG_AW-1:2]))
            REG_SRC_X:    prdata = CFG_DW'(r_src_x);
            REG_SRC_Y:    prdata = CFG_DW'(r_src_y);
            REG_SRC_Z:    prdata = CFG_DW'(r_src_z);
            REG_NEG_MASK: prdata = CFG_DW'(r_neg);
            REG_DET_NEG:  prdata = CFG_DW'(r_det);
            REG_SCALE:    prdata = CFG_DW'(r_scale);
            default:      prdata = '0;
        endcase
    end

    // Basis check: a true permutation, nonzero scale, and handedness matching the determinant.
    assign w_perm_ok = (r_src_x != SRC_NONE) && (r_src_y != SRC_NONE) && (r_src_z != SRC_NONE)
                       && (r_src_x != r_src_y) && (r_src_x != r_src_z) && (r_src_y != r_src_z);
    assign w_parity  = (^r_neg) ^ (r_src_x > r_src_y) ^ (r_src_x > r_src_z)
                       ^ (r_src_y > r_src_z);

    assign w_cfg.src      = {r_src_z, r_src_y, r_src_x};
    assign w_cfg.neg      = r_neg;
    assign w_cfg.det      = r_det;
    assign w_cfg.scale    = r_scale;
    assign w_cfg.basis_ok = (r_scale != '0) && w_perm_ok && (w_parity == r_det);

    // The pipeline advances whenever the output register is free or being emptied.
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    abr_front #(
        .COMPONENT_WIDTH(CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_x        (i_in.in_x),
        .i_y        (i_in.in_y),
        .i_z        (i_in.in_z),
        .i_w        (i_in.in_w),
        .i_cfg      (w_cfg),
        .o_valid    (f_valid),
        .o_kind     (f_kind),
        .o_basis_ok (f_bv),
        .o_sat      (f_sat),
        .o_zero     (f_zero),
        .o_sg       (f_sg),
        .o_res      (f_res),
        .o_mag      (f_mag),
        .o_sum      (f_sum)
    );

    assign f_pay.side.kind = f_kind;
    assign f_pay.side.bv   = f_bv;
    assign f_pay.side.zero = f_zero;
    assign f_pay.side.sat  = f_sat;
    assign f_pay.side.sg   = f_sg;
    assign f_pay.side.res  = f_res;
    assign f_pay.m         = f_mag;

    // Square root of the summed squares, one root bit per cell.
    assign sq_v[0]    = f_valid;
    assign sq_s[0]    = f_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pay[0]  = f_pay;

    for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
        abr_sqrt_cell #(
            .LEN_W(LEN_W),
            .SQ_W (SQ_W),
            .PAY_W(SPAY_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_v[k]),
            .i_s     (sq_s[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_pay   (sq_pay[k]),
            .o_valid (sq_v[k+1]),
            .o_s     (sq_s[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_pay   (sq_pay[k+1])
        );
    end

    assign sq_last = t_sqrt_pay'(sq_pay[LEN_W]);

    // Each magnitude is divided by the length, one quotient bit per cell.
    assign dv_v[0]   = sq_v[LEN_W];
    assign dv_len[0] = sq_root[LEN_W];
    assign dv_pay[0] = sq_last.side;
    assign dv_q[0]   = '0;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dv_t[0][k] = (LEN_W + 1)'(sq_last.m[k]);
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        abr_div_cell #(
            .LEN_W(LEN_W),
            .QUO_W(QUO_W),
            .PAY_W(SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_v[k]),
            .i_len   (dv_len[k]),
            .i_t     (dv_t[k]),
            .i_q     (dv_q[k]),
            .i_pay   (dv_pay[k]),
            .o_valid (dv_v[k+1]),
            .o_len   (dv_len[k+1]),
            .o_t     (dv_t[k+1]),
            .o_q     (dv_q[k+1]),
            .o_pay   (dv_pay[k+1])
        );
    end

    assign dv_last = t_side'(dv_pay[QUO_W]);

    // Round half away from zero, clamp, and put the sign back on each quaternion part.
    always_comb begin
        logic [X_W-1:0] qr;
        logic [X_W-1:0] lim;
        logic [X_W-1:0] mag;
        for (int k = 0; k < 4; k++) begin
            qr  = X_W'(dv_q[QUO_W][k])
                  + X_W'(dv_t[QUO_W][k] >= (LEN_W + 1)'(dv_len[QUO_W]));
            lim = dv_last.sg[k] ? (X_W'(1) << (CW - 1)) : ((X_W'(1) << (CW - 1)) - X_W'(1));
            mag = (qr > lim) ? lim : qr;
            w_rot[k] = dv_last.sg[k] ? CW'(-mag) : CW'(mag);
        end
    end

    // Pick the result word for the item's kind.
    always_comb begin
        if (dv_last.kind) begin
            n_out_c = dv_last.zero ? '0 : w_rot;
        end else begin
            n_out_c = {{CW{1'b0}}, dv_last.res[2], dv_last.res[1], dv_last.res[0]};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= dv_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_kind <= dv_last.kind;
            r_out_sat  <= dv_last.sat & ~dv_last.kind;
            r_out_bv   <= dv_last.bv;
            r_out_c    <= n_out_c;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.out_x       = r_out_c[0];
    assign o_out.out_y       = r_out_c[1];
    assign o_out.out_z       = r_out_c[2];
    assign o_out.out_w       = r_out_c[3];
    assign o_out.saturated   = r_out_sat;
    assign o_out.basis_valid = r_out_bv;

    // A position word never carries a real part.
    `ASSERT_SAME(a_pos_w_zero, i_clk, i_rst_n,
                 r_out_valid && !r_out_kind, r_out_c[3] == '0,
                 "position word with nonzero w")
    // A rotation word never reports saturation.
    `ASSERT_SAME(a_rot_no_sat, i_clk, i_rst_n,
                 r_out_valid && r_out_kind, !r_out_sat,
                 "rotation word flagged as saturated")
    // Writing a zero scale makes the basis invalid.
    `ASSERT_NEXT(a_zero_scale, i_clk, i_rst_n,
                 w_cfg_wr && (paddr[CFG_AW-1:2] == REG_SCALE) && (pwdata == '0),
                 !w_cfg.basis_ok,
                 "zero scale left basis valid")

endmodule

[rtl/abr_front.sv]
module abr_front
    import abr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 32,
    localparam int CW = COMPONENT_WIDTH,
    localparam int LEN_W = (CW + 1 > 64) ? 64 : CW + 1,
    localparam int SQ_W = 2 * LEN_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_req_type,
    input  logic [CW-1:0]        i_x,
    input  logic [CW-1:0]        i_y,
    input  logic [CW-1:0]        i_z,
    input  logic [CW-1:0]        i_w,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output logic                 o_kind,
    output logic                 o_basis_ok,
    output logic                 o_sat,
    output logic                 o_zero,
    output logic [3:0]           o_sg,
    output logic [2:0][CW-1:0]   o_res,
    output logic [3:0][CW-1:0]   o_mag,
    output logic [SQ_W-1:0]      o_sum
);

    localparam int HL     = (CW + 1) / 2;
    localparam int HH     = CW - HL;
    localparam int PROD_W = CW + SCALE_W;
    localparam int RND_W  = PROD_W - SCALE_FRAC;
    localparam int SUM_W  = 2 * CW + 2;

    function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    logic [4:0] r_v;

    logic [3:0][CW-1:0] w_in;
    logic [3:0][CW-1:0] n0_m;
    logic [3:0]         n0_sg;

    logic               r0_kind, r0_bv;
    logic [3:0]         r0_sg;
    logic [3:0][CW-1:0] r0_m;

    logic               r1_kind, r1_bv;
    logic [3:0]         r1_sg;
    logic [3:0][CW-1:0] r1_m;
    logic [HL+SCALE_W-1:0] r1_pl [3];
    logic [HH+SCALE_W-1:0] r1_ph [3];
    logic [2*HL-1:0]       r1_ll [4];
    logic [CW-1:0]         r1_lh [4];
    logic [2*HH-1:0]       r1_hh [4];

    logic [2:0][CW-1:0] n2_res;
    logic               n2_sat;
    logic [SUM_W-1:0]   n2_sq [4];

    logic               r2_kind, r2_bv, r2_sat;
    logic [3:0]         r2_sg;
    logic [3:0][CW-1:0] r2_m;
    logic [2:0][CW-1:0] r2_res;
    logic [SUM_W-1:0]   r2_sq [4];

    logic               r3_kind, r3_bv, r3_sat;
    logic [3:0]         r3_sg;
    logic [3:0][CW-1:0] r3_m;
    logic [2:0][CW-1:0] r3_res;
    logic [SUM_W-1:0]   r3_a, r3_b;

    logic [SUM_W-1:0]   w_sum;

    logic               r4_kind, r4_bv, r4_sat, r4_zero;
    logic [3:0]         r4_sg;
    logic [3:0][CW-1:0] r4_m;
    logic [2:0][CW-1:0] r4_res;
    logic [SQ_W-1:0]    r4_s;

    assign w_in = {i_w, i_z, i_y, i_x};

    // Permute and sign the components; rotations also take the determinant sign.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_cfg.src[i] == SRC_NONE) begin
                n0_m[i]  = '0;
                n0_sg[i] = 1'b0;
            end else begin
                n0_m[i]  = mag_of(w_in[i_cfg.src[i]]);
                n0_sg[i] = w_in[i_cfg.src[i]][CW-1] ^ i_cfg.neg[i]
                           ^ (i_req_type & i_cfg.det);
            end
        end
        n0_m[3]  = mag_of(i_w);
        n0_sg[3] = i_w[CW-1];
    end

    // Position: add the half-split partial products, round, clamp; also build each square.
    always_comb begin
        logic [PROD_W-1:0] p;
        logic [RND_W-1:0]  rnd;
        logic [RND_W-1:0]  lim;
        logic [RND_W-1:0]  mag;
        n2_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p   = (PROD_W'(r1_ph[i]) << HL) + PROD_W'(r1_pl[i])
                  + (PROD_W'(1) << (SCALE_FRAC - 1));
            rnd = RND_W'(p >> SCALE_FRAC);
            lim = r1_sg[i] ? (RND_W'(1) << (CW - 1)) : ((RND_W'(1) << (CW - 1)) - RND_W'(1));
            mag = (rnd > lim) ? lim : rnd;
            n2_sat    = n2_sat | (rnd > lim);
            n2_res[i] = r1_sg[i] ? CW'(-mag) : CW'(mag);
        end
        for (int i = 0; i < 4; i++) begin
            n2_sq[i] = (SUM_W'(r1_hh[i]) << (2 * HL)) + (SUM_W'(r1_lh[i]) << (HL + 1))
                       + SUM_W'(r1_ll[i]);
        end
    end

    assign w_sum = r3_a + r3_b;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_kind <= i_req_type;
            r0_bv   <= i_cfg.basis_ok;
            r0_sg   <= n0_sg;
            r0_m    <= n0_m;

            r1_kind <= r0_kind;
            r1_bv   <= r0_bv;
            r1_sg   <= r0_sg;
            r1_m    <= r0_m;
            for (int i = 0; i < 3; i++) begin
                r1_pl[i] <= (HL + SCALE_W)'(r0_m[i][HL-1:0]) * (HL + SCALE_W)'(i_cfg.scale);
                r1_ph[i] <= (HH + SCALE_W)'(r0_m[i][CW-1:HL]) * (HH + SCALE_W)'(i_cfg.scale);
            end
            for (int i = 0; i < 4; i++) begin
                r1_ll[i] <= (2 * HL)'(r0_m[i][HL-1:0]) * (2 * HL)'(r0_m[i][HL-1:0]);
                r1_lh[i] <= CW'(r0_m[i][HL-1:0]) * CW'(r0_m[i][CW-1:HL]);
                r1_hh[i] <= (2 * HH)'(r0_m[i][CW-1:HL]) * (2 * HH)'(r0_m[i][CW-1:HL]);
            end

            r2_kind <= r1_kind;
            r2_bv   <= r1_bv;
            r2_sg   <= r1_sg;
            r2_m    <= r1_m;
            r2_res  <= n2_res;
            r2_sat  <= n2_sat;
            r2_sq   <= n2_sq;

            r3_kind <= r2_kind;
            r3_bv   <= r2_bv;
            r3_sg   <= r2_sg;
            r3_m    <= r2_m;
            r3_res  <= r2_res;
            r3_sat  <= r2_sat;
            r3_a    <= r2_sq[0] + r2_sq[1];
            r3_b    <= r2_sq[2] + r2_sq[3];

            r4_kind <= r3_kind;
            r4_bv   <= r3_bv;
            r4_sg   <= r3_sg;
            r4_m    <= r3_m;
            r4_res  <= r3_res;
            r4_sat  <= r3_sat;
            r4_zero <= (w_sum == '0);
            r4_s    <= (|(w_sum >> SQ_W)) ? '1 : SQ_W'(w_sum);
        end
    end

    assign o_valid    = r_v[4];
    assign o_kind     = r4_kind;
    assign o_basis_ok = r4_bv;
    assign o_sat      = r4_sat;
    assign o_zero     = r4_zero;
    assign o_sg       = r4_sg;
    assign o_res      = r4_res;
    assign o_mag      = r4_m;
    assign o_sum      = r4_s;

endmodule

[rtl/abr_sqrt_cell.sv]
module abr_sqrt_cell #(
    parameter int LEN_W = 33,
    parameter int SQ_W  = 66,
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SQ_W-1:0]  i_s,
    input  logic [LEN_W+1:0] i_rem,
    input  logic [LEN_W-1:0] i_root,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [SQ_W-1:0]  o_s,
    output logic [LEN_W+1:0] o_rem,
    output logic [LEN_W-1:0] o_root,
    output logic [PAY_W-1:0] o_pay
);

    logic [LEN_W+3:0] w_t;
    logic [LEN_W+3:0] w_trial;
    logic             w_ge;

    // One root digit: bring down two bits and try the next odd trial value.
    assign w_t     = {i_rem, i_s[SQ_W-1 -: 2]};
    assign w_trial = (LEN_W + 4)'({i_root, 2'b01});
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s    <= i_s << 2;
            o_rem  <= w_ge ? (LEN_W + 2)'(w_t - w_trial) : (LEN_W + 2)'(w_t);
            o_root <= {i_root[LEN_W-2:0], w_ge};
            o_pay  <= i_pay;
        end
    end

endmodule

[rtl/abr_div_cell.sv]
module abr_div_cell #(
    parameter int LEN_W = 33,
    parameter int QUO_W = 31,
    parameter int PAY_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [3:0][LEN_W:0]   i_t,
    input  logic [3:0][QUO_W-1:0] i_q,
    input  logic [PAY_W-1:0]      i_pay,
    output logic                  o_valid,
    output logic [LEN_W-1:0]      o_len,
    output logic [3:0][LEN_W:0]   o_t,
    output logic [3:0][QUO_W-1:0] o_q,
    output logic [PAY_W-1:0]      o_pay
);

    logic [3:0][LEN_W:0]   n_t;
    logic [3:0][QUO_W-1:0] n_q;

    // One quotient bit on each of the four lanes; the partial remainder is doubled on.
    always_comb begin
        logic             ge;
        logic [LEN_W:0]   r;
        for (int k = 0; k < 4; k++) begin
            ge     = (i_t[k] >= (LEN_W + 1)'(i_len));
            r      = ge ? (i_t[k] - (LEN_W + 1)'(i_len)) : i_t[k];
            n_t[k] = {r[LEN_W-1:0], 1'b0};
            n_q[k] = {i_q[k][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len <= i_len;
            o_t   <= n_t;
            o_q   <= n_q;
            o_pay <= i_pay;
        end
    end

endmodule
